@@ hdl/crcls_pkg.sv @@
package crcls_pkg;

    // Position arithmetic.
    localparam int POS_BITS = 18;
    localparam int POS_W    = POS_BITS + 1;
    localparam int WIDE_W   = POS_W + 3;

    // Field widths.
    localparam int MODE_W       = 3;
    localparam int LEN_W        = 16;
    localparam int RSTART_W     = 17;
    localparam int COORD_W      = 17;
    localparam int OFFSET_W     = 16;
    localparam int DIST_W       = 16;
    localparam int CLASS_W      = 2;
    localparam int SPAN_START_W = 18;
    localparam int SPAN_END_W   = 19;
    localparam int COUNT_W      = 2;

    // Stream packing.
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 4;
    localparam int M_TDATA_W = 56;
    localparam int M_TUSER_W = 2;

    // Configuration port.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 17;

    localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_START     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_END       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CUT_OFFSET       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_DISTANCE_CUT     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_REFERENCE_LENGTH = 3'd4;

    // CIGAR operation kinds.
    localparam logic [MODE_W-1:0] MODE_MATCH    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_DELETION = 3'd1;
    localparam logic [MODE_W-1:0] MODE_INSERT   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_OTHER    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_NONE     = 3'd4;

    // Read classes.
    localparam logic [CLASS_W-1:0] CLS_REJECT    = 2'd0;
    localparam logic [CLASS_W-1:0] CLS_ORDINARY  = 2'd1;
    localparam logic [CLASS_W-1:0] CLS_LARGE_DEL = 2'd2;

    // Thresholds.
    localparam logic [DIST_W-1:0]         DIST_SAT      = 16'd50000;
    localparam logic signed [WIDE_W-1:0]  NEAR_CUT_W    = 13;
    localparam logic [LEN_W-1:0]          LONG_DEL      = 16'd50;
    localparam logic [LEN_W-1:0]          MIN_SECOND    = 16'd13;
    localparam logic [WIDE_W-1:0]         EDGE_MARGIN_W = 40;
    localparam logic [SPAN_START_W-1:0]   EDGE_MARGIN_S = 18'd40;
    localparam logic [COUNT_W-1:0]        COUNT_SAT     = 2'd2;

    typedef struct packed {
        logic rej;
        logic del;
        logic ins;
    } read_flags_t;

    function automatic logic [WIDE_W-1:0] abs_diff(input logic signed [WIDE_W-1:0] a,
                                                   input logic signed [WIDE_W-1:0] b);
        logic signed [WIDE_W-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return WIDE_W'(d);
    endfunction

endpackage

@@ hdl/cigar_read_classifier_unit.sv @@
// Channel   Direction  Transaction                 Payload
// s_axis    in         one CIGAR operation         tdata: op_length, ref_start; tuser: mode,
//                                                  first_op; tlast: last_op
// m_axis    out        one read classification     tdata: spans, distance, flags;
//                                                  tuser: read_class
// cfg       in         one register write          cfg_index, cfg_data
//
// Every operation passes the input register, where the read state is updated by a
// single pass of adds and compares, so one transaction is accepted per cycle while
// no last operation is held; an operation marked last writes its classification into
// the result register as it moves on; the result register holds it until it is taken.
// A stall on m_axis only holds back an operation marked last; other operations keep
// flowing past a waiting result.
// Reset is synchronous and active low; it clears configuration and read state.
module cigar_read_classifier_unit import crcls_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [15:0] op_length, [32:16] ref_start, [39:33] zero.
    input  logic [S_TDATA_W-1:0]   s_axis_tdata,
    // [2:0] mode, [3] first_op.
    input  logic [S_TUSER_W-1:0]   s_axis_tuser,
    input  logic                   s_axis_tlast,

    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [17:0] span_start, [36:18] span_end, [52:37] cut_distance,
    // [53] overlaps_target, [54] insertion_near_cut, [55] deletion_near_cut.
    output logic [M_TDATA_W-1:0]   m_axis_tdata,
    // [1:0] read_class.
    output logic [M_TUSER_W-1:0]   m_axis_tuser,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // Configuration registers.
    logic [COORD_W-1:0]  target_start_reg;
    logic [COORD_W-1:0]  target_end_reg;
    logic [OFFSET_W-1:0] cut_offset_reg;
    logic [DIST_W-1:0]   distance_cut_reg;
    logic [COORD_W-1:0]  reference_length_reg;

    // Input register.
    logic                in_valid_reg;
    logic [MODE_W-1:0]   in_mode_reg;
    logic [LEN_W-1:0]    in_len_reg;
    logic [RSTART_W-1:0] in_rs_reg;
    logic                in_first_reg;
    logic                in_last_reg;

    // Read state.
    logic [POS_W-1:0]        pos_reg,       pos_next;
    logic [SPAN_START_W-1:0] start_reg,     start_next;
    logic [DIST_W-1:0]       near_reg,      near_next;
    logic [COUNT_W-1:0]      ldel_cnt_reg,  ldel_cnt_next;
    logic [LEN_W-1:0]        lmatch_reg,    lmatch_next;
    logic [LEN_W-1:0]        smatch_reg,    smatch_next;
    logic [COUNT_W-1:0]      match_cnt_reg, match_cnt_next;
    read_flags_t             flags_reg,     flags_next;

    // Result register.
    logic                    out_valid_reg;
    logic [CLASS_W-1:0]      out_class_reg,  out_class_next;
    logic [SPAN_START_W-1:0] out_start_reg,  out_start_next;
    logic [SPAN_END_W-1:0]   out_end_reg,    out_end_next;
    logic [DIST_W-1:0]       out_dist_reg,   out_dist_next;
    logic                    out_ovl_reg,    out_ovl_next;
    logic                    out_ins_reg,    out_ins_next;
    logic                    out_del_reg,    out_del_next;

    logic in_accept;
    logic advance;

    // Working values of the single pass.
    logic [SPAN_START_W-1:0]  start_one;
    logic [POS_W-1:0]         cur_pos;
    logic [SPAN_START_W-1:0]  cur_start;
    logic [DIST_W-1:0]        cur_near;
    read_flags_t              cur_flags;
    logic signed [WIDE_W-1:0] pos_w, len_w, cut_w, ts_w, te_w, rl_w, end_w, pos_new;
    logic [WIDE_W-1:0]        d_cut, d_ts, d_te, d_edge;
    logic [DIST_W-1:0]        near_step, near_end;
    logic                     meets_target;

    // The input register moves on unless it holds a last operation whose result
    // cannot yet be written.
    assign advance       = in_valid_reg && (!in_last_reg || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_start_reg     <= '0;
            target_end_reg       <= '0;
            cut_offset_reg       <= '0;
            distance_cut_reg     <= '0;
            reference_length_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_TARGET_START:     target_start_reg     <= cfg_data[COORD_W-1:0];
                CFG_TARGET_END:       target_end_reg       <= cfg_data[COORD_W-1:0];
                CFG_CUT_OFFSET:       cut_offset_reg       <= cfg_data[OFFSET_W-1:0];
                CFG_DISTANCE_CUT:     distance_cut_reg     <= cfg_data[DIST_W-1:0];
                CFG_REFERENCE_LENGTH: reference_length_reg <= cfg_data[COORD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_accept) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
        if (in_accept) begin
            in_mode_reg  <= s_axis_tuser[MODE_W-1:0];
            in_first_reg <= s_axis_tuser[MODE_W];
            in_len_reg   <= s_axis_tdata[LEN_W-1:0];
            in_rs_reg    <= s_axis_tdata[LEN_W+RSTART_W-1:LEN_W];
            in_last_reg  <= s_axis_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            start_reg     <= '0;
            near_reg      <= DIST_SAT;
            ldel_cnt_reg  <= '0;
            lmatch_reg    <= '0;
            smatch_reg    <= '0;
            match_cnt_reg <= '0;
            flags_reg     <= '0;
        end else if (advance) begin
            pos_reg       <= pos_next;
            start_reg     <= start_next;
            near_reg      <= near_next;
            ldel_cnt_reg  <= ldel_cnt_next;
            lmatch_reg    <= lmatch_next;
            smatch_reg    <= smatch_next;
            match_cnt_reg <= match_cnt_next;
            flags_reg     <= flags_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && in_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance && in_last_reg) begin
            out_class_reg <= out_class_next;
            out_start_reg <= out_start_next;
            out_end_reg   <= out_end_next;
            out_dist_reg  <= out_dist_next;
            out_ovl_reg   <= out_ovl_next;
            out_ins_reg   <= out_ins_next;
            out_del_reg   <= out_del_next;
        end
    end

    always_comb begin
        // A first operation starts from a fresh read state.
        start_one      = {1'b0, in_rs_reg} + SPAN_START_W'(1);
        cur_pos        = pos_reg;
        cur_start      = start_reg;
        cur_near       = near_reg;
        cur_flags      = flags_reg;
        ldel_cnt_next  = ldel_cnt_reg;
        lmatch_next    = lmatch_reg;
        smatch_next    = smatch_reg;
        match_cnt_next = match_cnt_reg;
        if (in_first_reg) begin
            cur_pos        = POS_W'(start_one);
            cur_start      = start_one;
            cur_near       = DIST_SAT;
            cur_flags      = '0;
            cur_flags.rej  = start_one < EDGE_MARGIN_S;
            ldel_cnt_next  = '0;
            lmatch_next    = '0;
            smatch_next    = '0;
            match_cnt_next = '0;
        end
        flags_next = cur_flags;
        if (in_mode_reg == MODE_NONE) begin
            flags_next.rej = 1'b1;
        end
        start_next = cur_start;

        pos_w = {{(WIDE_W-POS_W){cur_pos[POS_W-1]}}, cur_pos};
        len_w = {{(WIDE_W-LEN_W){1'b0}}, in_len_reg};
        ts_w  = {{(WIDE_W-COORD_W){1'b0}}, target_start_reg};
        te_w  = {{(WIDE_W-COORD_W){1'b0}}, target_end_reg};
        rl_w  = {{(WIDE_W-COORD_W){1'b0}}, reference_length_reg};
        cut_w = ts_w + {{(WIDE_W-OFFSET_W){1'b0}}, cut_offset_reg};

        // Fold the distance from the position before this operation.
        d_cut     = abs_diff(pos_w, cut_w);
        near_step = (d_cut < {{(WIDE_W-DIST_W){1'b0}}, cur_near}) ? d_cut[DIST_W-1:0]
                                                                  : cur_near;

        pos_new = pos_w;
        case (in_mode_reg)
            MODE_MATCH: begin
                if (in_len_reg > lmatch_next) begin
                    smatch_next = lmatch_next;
                    lmatch_next = in_len_reg;
                end else if (in_len_reg > smatch_next) begin
                    smatch_next = in_len_reg;
                end
                if (match_cnt_next < COUNT_SAT) begin
                    match_cnt_next = match_cnt_next + COUNT_W'(1);
                end
                pos_new = pos_w + len_w;
            end
            MODE_DELETION: begin
                if (in_len_reg >= LONG_DEL && ldel_cnt_next < COUNT_SAT) begin
                    ldel_cnt_next = ldel_cnt_next + COUNT_W'(1);
                end
                if (!((pos_w + len_w < cut_w - NEAR_CUT_W) || (cut_w + NEAR_CUT_W < pos_w))) begin
                    flags_next.del = 1'b1;
                end
                pos_new = pos_w + len_w;
            end
            MODE_INSERT: begin
                if (!((pos_w < cut_w - NEAR_CUT_W) || (cut_w + NEAR_CUT_W < pos_w - len_w))) begin
                    flags_next.ins = 1'b1;
                end
                pos_new = pos_w - len_w;
            end
            default: begin
            end
        endcase
        pos_next = pos_new[POS_W-1:0];

        // At the end of a read the end position is also measured against the target bounds.
        end_w    = {{(WIDE_W-POS_W){pos_next[POS_W-1]}}, pos_next};
        d_ts     = abs_diff(end_w, ts_w);
        d_te     = abs_diff(end_w, te_w);
        near_end = near_step;
        if (d_ts < {{(WIDE_W-DIST_W){1'b0}}, near_end}) begin
            near_end = d_ts[DIST_W-1:0];
        end
        if (d_te < {{(WIDE_W-DIST_W){1'b0}}, near_end}) begin
            near_end = d_te[DIST_W-1:0];
        end
        near_next = in_last_reg ? near_end : near_step;

        meets_target = !((end_w < ts_w) || ({1'b0, target_end_reg} < cur_start));
        d_edge       = abs_diff(rl_w, end_w);

        out_class_next = CLS_ORDINARY;
        out_start_next = cur_start;
        out_end_next   = SPAN_END_W'(pos_next);
        out_dist_next  = DIST_SAT;
        out_ovl_next   = 1'b0;
        out_ins_next   = flags_next.ins;
        out_del_next   = flags_next.del;
        if (flags_next.rej) begin
            // Unaligned or too close to the reference start: class, spans and flags are cleared.
            out_class_next = CLS_REJECT;
            out_start_next = '0;
            out_end_next   = '0;
            out_ins_next   = 1'b0;
            out_del_next   = 1'b0;
        end else if (ldel_cnt_next >= COUNT_SAT) begin
            // Two long deletions make the read ambiguous.
            out_class_next = CLS_REJECT;
        end else begin
            out_ovl_next = meets_target && (near_next < distance_cut_reg);
            // A long deletion has been seen exactly when the deletion count is nonzero.
            if (match_cnt_next == COUNT_W'(1)) begin
                out_class_next = CLS_ORDINARY;
            end else if (ldel_cnt_next != '0 && smatch_next >= MIN_SECOND) begin
                if (out_ovl_next) begin
                    out_dist_next = near_next;
                    if (d_edge < EDGE_MARGIN_W) begin
                        out_class_next = CLS_REJECT;
                        out_start_next = '0;
                        out_end_next   = '0;
                    end else begin
                        out_class_next = CLS_LARGE_DEL;
                    end
                end else begin
                    out_class_next = CLS_REJECT;
                end
            end else begin
                out_class_next = CLS_ORDINARY;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_class_reg;
    assign m_axis_tdata  = {out_del_reg, out_ins_reg, out_ovl_reg, out_dist_reg,
                            out_end_reg, out_start_reg};

endmodule

@@ hdl/crcls_checker.sv @@
module crcls_checker import crcls_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata,
    input logic [M_TUSER_W-1:0] m_axis_tuser
);

    logic [DIST_W-1:0] cut_dist;
    logic              ovl;

    assign cut_dist = m_axis_tdata[52:37];
    assign ovl      = m_axis_tdata[53];

    // No result survives a reset.
    assert property (@(posedge aclk) !aresetn |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // A stalled result holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // A large deletion is only reported for a read that overlaps the target.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser == CLS_LARGE_DEL |-> ovl)
        else $error("large deletion without overlap");

    // A measured distance is only reported together with an overlap.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && cut_dist != DIST_SAT |-> ovl)
        else $error("distance reported without overlap");

    // The distance never exceeds its saturation value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> cut_dist <= DIST_SAT)
        else $error("distance above saturation");

endmodule

bind cigar_read_classifier_unit crcls_checker u_crcls_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

@@ bench/read_class_checker.sv @@
`timescale 1ns / 1ps

// Watches the three channels of the classifier, predicts one classification per
// operation marked last and compares it field by field with what the block delivers.
module read_class_checker import crcls_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic [S_TDATA_W-1:0]   s_axis_tdata,
    input  logic [S_TUSER_W-1:0]   s_axis_tuser,
    input  logic                   s_axis_tlast,

    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [M_TDATA_W-1:0]   m_axis_tdata,
    input  logic [M_TUSER_W-1:0]   m_axis_tuser,

    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,

    output int                     fault_count,
    output int                     outstanding
);

    localparam longint NEAR_CUT_SPAN = 13;
    localparam longint LONG_DEL_LEN  = 50;
    localparam longint SECOND_MIN    = 13;
    localparam longint END_MARGIN    = 40;
    localparam longint DIST_CAP      = 50000;

    typedef struct packed {
        logic [CLASS_W-1:0]      read_class;
        logic [SPAN_START_W-1:0] span_start;
        logic [SPAN_END_W-1:0]   span_end;
        logic [DIST_W-1:0]       cut_distance;
        logic                    overlaps_target;
        logic                    insertion_near_cut;
        logic                    deletion_near_cut;
    } read_verdict_t;

    // Configuration copy.
    logic [COORD_W-1:0]  tgt_start;
    logic [COORD_W-1:0]  tgt_end;
    logic [OFFSET_W-1:0] cut_ofs;
    logic [DIST_W-1:0]   near_limit;
    logic [COORD_W-1:0]  ref_len;

    // Per-read state.
    logic signed [POS_W-1:0]  walk_pos;
    logic [SPAN_START_W-1:0]  read_start;
    logic [DIST_W-1:0]        near_dist;
    logic signed [COORD_W-1:0] long_del;
    logic [COUNT_W-1:0]       long_del_cnt;
    logic [LEN_W-1:0]         top_match;
    logic [LEN_W-1:0]         runner_match;
    logic [COUNT_W-1:0]       match_cnt;
    read_flags_t              rflags;

    read_verdict_t expected_verdicts[$];
    int faults;
    int results_seen;

    function automatic longint gap(input longint a, input longint b);
        return (a > b) ? a - b : b - a;
    endfunction

    task automatic fold_gap(input longint d);
        if (d < longint'(near_dist)) near_dist = 16'(d);
    endtask

    task automatic clear_read();
        walk_pos     = '0;
        read_start   = '0;
        near_dist    = 16'(DIST_CAP);
        long_del     = -17'sd1;
        long_del_cnt = '0;
        top_match    = '0;
        runner_match = '0;
        match_cnt    = '0;
        rflags       = '0;
    endtask

    task automatic walk_cigar_op(input logic [MODE_W-1:0] mode, input logic [LEN_W-1:0] len,
                                 input logic [RSTART_W-1:0] rs, input logic first,
                                 input logic last);
        longint cut;
        longint ts;
        longint te;
        longint pos;
        longint l;
        longint send;
        longint sstart;
        read_verdict_t v;
        cut = longint'(tgt_start) + longint'(cut_ofs);
        ts  = longint'(tgt_start);
        te  = longint'(tgt_end);
        l   = longint'(len);

        if (first) begin
            clear_read();
            read_start = 18'(longint'(rs) + 1);
            walk_pos   = 19'(longint'(rs) + 1);
            if (longint'(rs) + 1 < END_MARGIN) rflags.rej = 1'b1;
        end
        if (mode == MODE_NONE) rflags.rej = 1'b1;

        pos = longint'(walk_pos);
        fold_gap(gap(pos, cut));
        case (mode)
            MODE_MATCH: begin
                if (len > top_match) begin
                    runner_match = top_match;
                    top_match    = len;
                end else if (len > runner_match) begin
                    runner_match = len;
                end
                if (match_cnt < COUNT_SAT) match_cnt = match_cnt + 1'b1;
                pos = pos + l;
            end
            MODE_DELETION: begin
                if (l >= LONG_DEL_LEN && long_del_cnt < COUNT_SAT)
                    long_del_cnt = long_del_cnt + 1'b1;
                if (!(pos + l < cut - NEAR_CUT_SPAN || cut + NEAR_CUT_SPAN < pos))
                    rflags.del = 1'b1;
                if (l > longint'(long_del)) long_del = {1'b0, len};
                pos = pos + l;
            end
            MODE_INSERT: begin
                if (!(pos < cut - NEAR_CUT_SPAN || cut + NEAR_CUT_SPAN < pos - l))
                    rflags.ins = 1'b1;
                pos = pos - l;
            end
            default: begin
            end
        endcase
        walk_pos = 19'(pos);

        if (!last) return;

        send   = longint'(walk_pos);
        sstart = longint'(read_start);
        fold_gap(gap(send, ts));
        fold_gap(gap(send, te));
        v = '0;
        v.cut_distance       = 16'(DIST_CAP);
        v.insertion_near_cut = rflags.ins;
        v.deletion_near_cut  = rflags.del;

        if (rflags.rej) begin
            v.read_class         = CLS_REJECT;
            sstart               = 0;
            send                 = 0;
            v.insertion_near_cut = 1'b0;
            v.deletion_near_cut  = 1'b0;
        end else if (long_del_cnt >= COUNT_SAT) begin
            v.read_class = CLS_REJECT;
        end else begin
            if (!(send < ts || te < sstart))
                v.overlaps_target = (near_dist < near_limit);
            if (match_cnt == 2'd1) begin
                v.read_class = CLS_ORDINARY;
            end else if (longint'(long_del) >= LONG_DEL_LEN &&
                         longint'(runner_match) >= SECOND_MIN) begin
                if (v.overlaps_target) begin
                    v.cut_distance = near_dist;
                    if (gap(longint'(ref_len), send) < END_MARGIN) begin
                        v.read_class = CLS_REJECT;
                        sstart       = 0;
                        send         = 0;
                    end else begin
                        v.read_class = CLS_LARGE_DEL;
                    end
                end else begin
                    v.read_class = CLS_REJECT;
                end
            end else begin
                v.read_class = CLS_ORDINARY;
            end
        end
        v.span_start = 18'(sstart);
        v.span_end   = 19'(send);
        expected_verdicts = {expected_verdicts, v};
    endtask

    task automatic check_field(input string label, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            if (faults < 10)
                $display("read result %0d: %s expected 0x%0h, got 0x%0h",
                         results_seen, label, want, got);
            faults++;
        end
    endtask

    always @(posedge aclk) begin
        read_verdict_t want;
        read_verdict_t got;
        if (!aresetn) begin
            tgt_start  = '0;
            tgt_end    = '0;
            cut_ofs    = '0;
            near_limit = '0;
            ref_len    = '0;
            clear_read();
            expected_verdicts.delete();
            faults       = 0;
            results_seen = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_TARGET_START:     tgt_start  = cfg_data[COORD_W-1:0];
                    CFG_TARGET_END:       tgt_end    = cfg_data[COORD_W-1:0];
                    CFG_CUT_OFFSET:       cut_ofs    = cfg_data[OFFSET_W-1:0];
                    CFG_DISTANCE_CUT:     near_limit = cfg_data[DIST_W-1:0];
                    CFG_REFERENCE_LENGTH: ref_len    = cfg_data[COORD_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                walk_cigar_op(s_axis_tuser[2:0], s_axis_tdata[15:0], s_axis_tdata[32:16],
                              s_axis_tuser[3], s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready) begin
                got.read_class         = m_axis_tuser[1:0];
                got.span_start         = m_axis_tdata[17:0];
                got.span_end           = m_axis_tdata[36:18];
                got.cut_distance       = m_axis_tdata[52:37];
                got.overlaps_target    = m_axis_tdata[53];
                got.insertion_near_cut = m_axis_tdata[54];
                got.deletion_near_cut  = m_axis_tdata[55];
                if (expected_verdicts.size() == 0) begin
                    if (faults < 10)
                        $display("read result %0d arrived with no read pending", results_seen);
                    faults++;
                end else begin
                    want = expected_verdicts.pop_front();
                    check_field("read_class", 32'(want.read_class), 32'(got.read_class));
                    check_field("span_start", 32'(want.span_start), 32'(got.span_start));
                    check_field("span_end", 32'(want.span_end), 32'(got.span_end));
                    check_field("cut_distance", 32'(want.cut_distance),
                                32'(got.cut_distance));
                    check_field("overlaps_target", 32'(want.overlaps_target),
                                32'(got.overlaps_target));
                    check_field("insertion_near_cut", 32'(want.insertion_near_cut),
                                32'(got.insertion_near_cut));
                    check_field("deletion_near_cut", 32'(want.deletion_near_cut),
                                32'(got.deletion_near_cut));
                end
                results_seen++;
            end
        end
        fault_count <= faults;
        outstanding <= expected_verdicts.size();
    end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps

// Top of the bench for the CIGAR read classifier. It drives CIGAR operations and register
// writes into the block, paces the result channel, and gives the verdict. All prediction
// and comparison is done by the checker instantiated beside the block.
module tb;
    import crcls_pkg::*;

    // Kinds beyond the defined ones; the block must treat them like "other".
    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

    // Cycles in which no transaction of any channel may pass before the run is abandoned.
    localparam int STALL_LIMIT = 4000;
    // Random operations to send in each random phase.
    localparam int PHASE_ITEMS = 88;
    // Quiet cycles after the last result, covering the block's pipeline depth.
    localparam int TAIL_CYCLES = 8;

    typedef enum {PACE_FREE, PACE_SEND_IDLE, PACE_RECV_STALL, PACE_BOTH} pace_t;

    logic aclk;
    logic aresetn = 1'b0;

    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata  = '0;
    logic [S_TUSER_W-1:0]   s_axis_tuser  = '0;
    logic                   s_axis_tlast  = 1'b0;

    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    logic [M_TUSER_W-1:0]   m_axis_tuser;

    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    int    fault_count;
    int    outstanding;
    pace_t pace   = PACE_FREE;
    int    center = 0;
    int    items_sent;
    int    quiet_cycles = 0;

    cigar_read_classifier_unit uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    read_class_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fault_count   (fault_count),
        .outstanding   (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // The result side stalls on its own, following the pace of the current phase.
    // In the free phases it is always ready.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= !((pace == PACE_RECV_STALL && $urandom_range(0, 99) < 81) ||
                               (pace == PACE_BOTH && $urandom_range(0, 99) < 37));
        end
    end

    // Watchdog: any transaction on any channel counts as progress. A block that hangs
    // or never delivers a pending result ends the run here.
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("cigar_read_classifier_unit verification failed");
            $finish;
        end
    end

    function automatic logic [MODE_W-1:0] pick_mode();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 30) return MODE_MATCH;
        if (roll < 55) return MODE_DELETION;
        if (roll < 75) return MODE_INSERT;
        if (roll < 85) return MODE_OTHER;
        if (roll < 90) return MODE_NONE;
        return 3'($urandom_range(5, 7));
    endfunction

    // Sends one CIGAR operation. In the idle phases the sender first rests a random
    // number of cycles with tvalid low; otherwise tvalid stays high from one
    // transaction to the next, so a single assignment per clock step is kept.
    task automatic push_op(input logic [MODE_W-1:0] mode, input logic [LEN_W-1:0] len,
                           input logic [RSTART_W-1:0] rs, input logic first,
                           input logic last);
        while ((pace == PACE_SEND_IDLE && $urandom_range(0, 99) < 81) ||
               (pace == PACE_BOTH && $urandom_range(0, 99) < 37)) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, rs, len};
        s_axis_tuser  <= {first, mode};
        s_axis_tlast  <= last;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        items_sent++;
    endtask

    // Writes all five registers back to back; the block is idle whenever this is called.
    task automatic write_config(input int ts, input int te, input int co, input int dc,
                                input int rl);
        logic [CFG_INDEX_W-1:0] idx [5];
        int                     val [5];
        idx = '{CFG_TARGET_START, CFG_TARGET_END, CFG_CUT_OFFSET, CFG_DISTANCE_CUT,
                CFG_REFERENCE_LENGTH};
        val = '{ts, te, co, dc, rl};
        for (int i = 0; i < 5; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= 17'(val[i]);
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
        end
        cfg_valid <= 1'b0;
        center = ts;
    endtask

    // Stops the input stream and waits until every pending classification has come
    // back, then lets the pipeline run empty. The first clock step lets the checker's
    // count take in the last transaction.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    // One random read. Most reads have the shape of a large-deletion candidate
    // (match, deletion, more operations, closing match) near the target, so that the
    // deep classification paths are reached; the rest are arbitrary operation lists,
    // and a few lack the first-operation mark and continue the previous read.
    task automatic random_read();
        int                 shape;
        int                 n_ops;
        int                 roll;
        logic [MODE_W-1:0]  op_mode;
        logic [LEN_W-1:0]   op_len;
        logic [RSTART_W-1:0] start;
        shape = $urandom_range(0, 99);
        n_ops = (shape < 65) ? $urandom_range(3, 6) : $urandom_range(1, 5);
        roll  = $urandom_range(0, 99);
        if (roll < 70) begin
            start = (center > 600) ? 17'(center - $urandom_range(0, 600))
                                   : 17'($urandom_range(0, 600));
        end else if (roll < 80) begin
            start = 17'($urandom_range(0, 40));
        end else if (roll < 85) begin
            start = '1;
        end else begin
            start = 17'($urandom);
        end
        for (int i = 0; i < n_ops; i++) begin
            if (shape < 65 && (i == 0 || i == n_ops - 1)) begin
                op_mode = MODE_MATCH;
            end else if (shape < 65 && i == 1) begin
                op_mode = MODE_DELETION;
            end else begin
                op_mode = pick_mode();
            end
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
                op_len = '0;
            end else if (roll < 6) begin
                op_len = '1;
            end else if (roll < 10) begin
                op_len = 16'($urandom);
            end else if (op_mode == MODE_DELETION) begin
                op_len = 16'($urandom_range(0, 700));
            end else if (op_mode == MODE_MATCH) begin
                op_len = 16'($urandom_range(0, 400));
            end else begin
                op_len = 16'($urandom_range(0, 60));
            end
            push_op(op_mode, op_len, (i == 0) ? start : 17'($urandom),
                    (i == 0) && (shape < 95), i == n_ops - 1);
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed reads. The target spans 1000 to 1400 with the cut at 1150.
        write_config(1000, 1400, 150, 60000, 20000);
        // A read with no alignment.
        push_op(MODE_NONE, 16'd100, 17'd900, 1'b1, 1'b1);
        // A start too close to the reference origin.
        push_op(MODE_MATCH, 16'd100, 17'd0, 1'b1, 1'b0);
        push_op(MODE_MATCH, 16'd100, 17'd0, 1'b0, 1'b1);
        // Unknown kinds between matches, one of them at the longest length.
        push_op(MODE_MATCH, 16'd100, 17'd900, 1'b1, 1'b0);
        push_op(MODE_SPARE_LO, 16'hFFFF, 17'h1FFFF, 1'b0, 1'b0);
        push_op(MODE_SPARE_HI, 16'd20, 17'd0, 1'b0, 1'b0);
        push_op(MODE_MATCH, 16'd100, 17'd0, 1'b0, 1'b1);
        // Two long deletions.
        push_op(MODE_MATCH, 16'd100, 17'd1000, 1'b1, 1'b0);
        push_op(MODE_DELETION, 16'd60, 17'd0, 1'b0, 1'b0);
        push_op(MODE_DELETION, 16'd60, 17'd0, 1'b0, 1'b0);
        push_op(MODE_MATCH, 16'd100, 17'd0, 1'b0, 1'b1);
        // A single match.
        push_op(MODE_MATCH, 16'd200, 17'd950, 1'b1, 1'b1);
        // A large deletion across the cut.
        push_op(MODE_MATCH, 16'd200, 17'd900, 1'b1, 1'b0);
        push_op(MODE_DELETION, 16'd300, 17'd0, 1'b0, 1'b0);
        push_op(MODE_MATCH, 16'd100, 17'd0, 1'b0, 1'b1);
        // A candidate far away from the target.
        push_op(MODE_MATCH, 16'd200, 17'd30000, 1'b1, 1'b0);
        push_op(MODE_DELETION, 16'd100, 17'd0, 1'b0, 1'b0);
        push_op(MODE_MATCH, 16'd100, 17'd0, 1'b0, 1'b1);
        // An operation without the first mark continues the read above.
        push_op(MODE_MATCH, 16'hFFFF, 17'd0, 1'b0, 1'b1);
        // An insertion right at the cut.
        push_op(MODE_MATCH, 16'd240, 17'd900, 1'b1, 1'b0);
        push_op(MODE_INSERT, 16'd10, 17'd0, 1'b0, 1'b0);
        push_op(MODE_MATCH, 16'd50, 17'd0, 1'b0, 1'b1);
        // The largest start and the longest deletion; the position still fits its width.
        push_op(MODE_DELETION, 16'hFFFF, 17'h1FFFF, 1'b1, 1'b1);
        drain();

        // Random phases, each with its own register setting and pace.
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin
                    write_config(1000, 1400, 150, 60000, 20000);
                    pace = PACE_FREE;
                end
                1: begin
                    write_config(0, 131071, 0, 65535, 131071);
                    pace = PACE_SEND_IDLE;
                end
                2: begin
                    write_config(131071, 0, 65535, 0, 0);
                    pace = PACE_RECV_STALL;
                end
                3: begin
                    write_config(50000, 50500, 250, 300, 50700);
                    pace = PACE_BOTH;
                end
                4: begin
                    write_config(2000, 2100, 40, 1000, 2300);
                    pace = PACE_FREE;
                end
                5: begin
                    write_config(1000, 1400, 150, 60000, 20000);
                    pace = PACE_BOTH;
                end
                6: begin
                    write_config(50000, 50500, 250, 300, 50700);
                    pace = PACE_SEND_IDLE;
                end
                default: begin
                    write_config(2000, 2100, 40, 1000, 2300);
                    pace = PACE_RECV_STALL;
                end
            endcase
            items_sent = 0;
            while (items_sent < PHASE_ITEMS) random_read();
            drain();
        end

        if (fault_count == 0 && outstanding == 0) begin
            $display("cigar_read_classifier_unit verification clean");
        end else begin
            $display("cigar_read_classifier_unit verification failed");
        end
        $finish;
    end

endmodule
